### hw/rtl/assert_macros.svh
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising edge out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

### hw/rtl/swqt_pkg.sv
// types and constants of the semaphore wait queue table
package swqt_pkg;

	localparam int KEY_W   = 32;
	localparam int PROC_W  = 5;
	localparam int NUM_PROCS = 32;

	typedef enum logic [1:0] {
		OP_INSERT      = 2'd0,
		OP_REMOVE_HEAD = 2'd1,
		OP_REMOVE_PROC = 2'd2,
		OP_PEEK_HEAD   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_NULL_KEY  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [PROC_W-1:0] head;
		logic [PROC_W-1:0] tail;
	} slot_word_t;

endpackage

### hw/rtl/swqt_ram.sv
// simple dual-port ram, one write and one registered read per cycle
module swqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/semaphore_wait_queue_table.sv
// semaphore wait queue table top level
// One item is processed at a time and answered with exactly one result. Insert, remove-head
// and peek scan the descriptor memory one entry per cycle for the key and stop once it is
// found; insert then updates in INS_A and INS_B (INS_B alone for a new key), remove-head in
// POP and, when others wait behind the head, POP_WR. Remove-process reads the slot of the
// process and goes to POP when it is at the head, else walks the link memory from the head
// to it and updates in RP_FIX. Null-key cases, inserts of a process already waiting and
// removals of a process not waiting are answered without a scan. The next item is taken
// once the result has been delivered. No clearing pass is needed after reset.
module semaphore_wait_queue_table #(
	parameter int NUM_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // opcode[1:0], key[33:2], proc_id[38:34], zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // status[1:0], proc_out[6:2], zero
	output logic        m_axis_tuser   // proc_valid
);

	localparam int IW = $clog2(NUM_ENTRIES);
	localparam int PW = swqt_pkg::PROC_W;
	localparam int KW = swqt_pkg::KEY_W;

	typedef enum logic [3:0] {
		IDLE, SCAN, POP, POP_WR, INS_A, INS_B, RP_SLOT, RP_CHK, RP_WALK, RP_FIX
	} state_t;

	state_t state_q;

	logic [NUM_ENTRIES-1:0]         busy_q;
	logic [swqt_pkg::NUM_PROCS-1:0] waiting_q;

	swqt_pkg::opcode_t op_q;
	logic [KW-1:0]     key_q;
	logic [PW-1:0]     pid_q;

	logic [IW-1:0] scan_q;
	logic          chk_vld_s1;
	logic [IW-1:0] chk_idx_s1;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;

	logic [IW-1:0] hit_idx_q;
	logic [KW-1:0] hit_key_q;
	logic [PW-1:0] hit_head_q;
	logic [PW-1:0] hit_tail_q;
	logic [PW-1:0] cur_q;

	logic              out_valid_q;
	swqt_pkg::status_t out_status_q;
	logic              out_pvalid_q;
	logic [PW-1:0]     out_proc_q;

	logic                 slot_we, slot_re;
	logic [IW-1:0]        slot_waddr, slot_raddr;
	swqt_pkg::slot_word_t slot_wdata, slot_rd;
	logic [$bits(swqt_pkg::slot_word_t)-1:0] slot_rdata;

	logic          link_we, link_re;
	logic [PW-1:0] link_waddr, link_raddr, link_wdata, link_rdata;

	logic          pslot_we, pslot_re;
	logic [PW-1:0] pslot_waddr, pslot_raddr;
	logic [IW-1:0] pslot_wdata, pslot_rdata;

	swqt_pkg::opcode_t in_op;
	logic [KW-1:0]     in_key;
	logic [PW-1:0]     in_pid;
	logic              in_acc;
	logic              hit;
	logic              last;
	logic              free_any;
	logic [IW-1:0]     free_sel;
	logic [PW-1:0]     done_proc;

	assign in_op  = swqt_pkg::opcode_t'(s_axis_tdata[1:0]);
	assign in_key = s_axis_tdata[33:2];
	assign in_pid = s_axis_tdata[38:34];

	assign s_axis_tready = (state_q == IDLE) && !out_valid_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_proc_q, out_status_q};
	assign m_axis_tuser  = out_pvalid_q;

	assign slot_rd  = swqt_pkg::slot_word_t'(slot_rdata);
	assign hit      = chk_vld_s1 && busy_q[chk_idx_s1] && (slot_rd.key == key_q);
	assign last     = (chk_idx_s1 == IW'(NUM_ENTRIES - 1));
	assign free_any = free_found_q || !busy_q[chk_idx_s1];
	assign free_sel = free_found_q ? free_idx_q : chk_idx_s1;
	assign done_proc = (op_q == swqt_pkg::OP_REMOVE_PROC) ? pid_q : hit_head_q;

	swqt_ram #(.WIDTH($bits(swqt_pkg::slot_word_t)), .DEPTH(NUM_ENTRIES)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
	);

	swqt_ram #(.WIDTH(PW), .DEPTH(swqt_pkg::NUM_PROCS)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.re(link_re), .raddr(link_raddr), .rdata(link_rdata)
	);

	swqt_ram #(.WIDTH(IW), .DEPTH(swqt_pkg::NUM_PROCS)) u_pslot_ram (
		.clk(clk), .we(pslot_we), .waddr(pslot_waddr), .wdata(pslot_wdata),
		.re(pslot_re), .raddr(pslot_raddr), .rdata(pslot_rdata)
	);

	always_comb begin
		slot_we     = 1'b0;
		slot_re     = 1'b0;
		slot_waddr  = hit_idx_q;
		slot_raddr  = scan_q;
		slot_wdata  = '{key: hit_key_q, head: hit_head_q, tail: hit_tail_q};
		link_we     = 1'b0;
		link_re     = 1'b0;
		link_waddr  = pid_q;
		link_raddr  = hit_head_q;
		link_wdata  = '0;
		pslot_we    = 1'b0;
		pslot_re    = 1'b0;
		pslot_waddr = pid_q;
		pslot_raddr = in_pid;
		pslot_wdata = hit_idx_q;
		unique case (state_q)
			IDLE: begin
				pslot_re = in_acc && (in_op == swqt_pkg::OP_REMOVE_PROC) && waiting_q[in_pid];
			end
			SCAN: begin
				slot_re = 1'b1;
			end
			POP: begin
				link_re = (hit_head_q != hit_tail_q);
			end
			POP_WR: begin
				slot_we    = 1'b1;
				slot_wdata = '{key: hit_key_q, head: link_rdata, tail: hit_tail_q};
			end
			INS_A: begin
				link_we    = 1'b1;
				link_waddr = hit_tail_q;
				link_wdata = pid_q;
			end
			INS_B: begin
				link_we    = 1'b1;
				slot_we    = 1'b1;
				slot_wdata = '{key: hit_key_q, head: hit_head_q, tail: pid_q};
				pslot_we   = 1'b1;
			end
			RP_SLOT: begin
				slot_re    = 1'b1;
				slot_raddr = pslot_rdata;
			end
			RP_CHK: begin
				link_re    = (slot_rd.head != pid_q);
				link_raddr = slot_rd.head;
			end
			RP_WALK: begin
				link_re    = 1'b1;
				link_raddr = (link_rdata == pid_q) ? pid_q : link_rdata;
			end
			RP_FIX: begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = link_rdata;
				slot_we    = (hit_tail_q == pid_q);
				slot_wdata = '{key: hit_key_q, head: hit_head_q, tail: cur_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			busy_q       <= '0;
			waiting_q    <= '0;
			out_valid_q  <= 1'b0;
			chk_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
			out_status_q <= swqt_pkg::ST_OK;
			out_pvalid_q <= 1'b0;
			out_proc_q   <= '0;
			op_q         <= swqt_pkg::OP_INSERT;
			key_q        <= '0;
			pid_q        <= '0;
			scan_q       <= '0;
			chk_idx_s1   <= '0;
			free_idx_q   <= '0;
			hit_idx_q    <= '0;
			hit_key_q    <= '0;
			hit_head_q   <= '0;
			hit_tail_q   <= '0;
			cur_q        <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					free_found_q <= 1'b0;
					scan_q       <= '0;
					if (in_acc) begin
						op_q  <= in_op;
						key_q <= in_key;
						pid_q <= in_pid;
						out_pvalid_q <= 1'b0;
						out_proc_q   <= '0;
						if (in_op == swqt_pkg::OP_INSERT && in_key == '0) begin
							out_valid_q  <= 1'b1;
							out_status_q <= swqt_pkg::ST_NULL_KEY;
						end else if (in_op == swqt_pkg::OP_INSERT && waiting_q[in_pid]) begin
							out_valid_q  <= 1'b1;
							out_status_q <= swqt_pkg::ST_NOT_FOUND;
						end else if (in_op == swqt_pkg::OP_REMOVE_PROC) begin
							if (waiting_q[in_pid]) begin
								state_q <= RP_SLOT;
							end else begin
								out_valid_q  <= 1'b1;
								out_status_q <= swqt_pkg::ST_NOT_FOUND;
							end
						end else if (in_key == '0) begin
							out_valid_q  <= 1'b1;
							out_status_q <= swqt_pkg::ST_NOT_FOUND;
						end else begin
							state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					chk_vld_s1 <= !(chk_vld_s1 && (hit || last));
					chk_idx_s1 <= scan_q;
					scan_q     <= scan_q + 1'b1;
					if (chk_vld_s1) begin
						if (!free_found_q && !busy_q[chk_idx_s1]) begin
							free_found_q <= 1'b1;
							free_idx_q   <= chk_idx_s1;
						end
						if (hit) begin
							hit_idx_q  <= chk_idx_s1;
							hit_key_q  <= slot_rd.key;
							hit_head_q <= slot_rd.head;
							hit_tail_q <= slot_rd.tail;
							unique case (op_q)
								swqt_pkg::OP_INSERT:      state_q <= INS_A;
								swqt_pkg::OP_REMOVE_HEAD: state_q <= POP;
								default: begin
									state_q      <= IDLE;
									out_valid_q  <= 1'b1;
									out_status_q <= swqt_pkg::ST_OK;
									out_pvalid_q <= 1'b1;
									out_proc_q   <= slot_rd.head;
								end
							endcase
						end else if (last) begin
							if (op_q == swqt_pkg::OP_INSERT && free_any) begin
								hit_idx_q  <= free_sel;
								hit_key_q  <= key_q;
								hit_head_q <= pid_q;
								state_q    <= INS_B;
							end else begin
								state_q      <= IDLE;
								out_valid_q  <= 1'b1;
								out_status_q <= (op_q == swqt_pkg::OP_INSERT) ?
									swqt_pkg::ST_NO_FREE : swqt_pkg::ST_NOT_FOUND;
							end
						end
					end
				end
				POP: begin
					if (hit_head_q == hit_tail_q) begin
						busy_q[hit_idx_q]     <= 1'b0;
						waiting_q[hit_head_q] <= 1'b0;
						state_q      <= IDLE;
						out_valid_q  <= 1'b1;
						out_status_q <= swqt_pkg::ST_OK;
						out_pvalid_q <= 1'b1;
						out_proc_q   <= done_proc;
					end else begin
						state_q <= POP_WR;
					end
				end
				POP_WR: begin
					waiting_q[hit_head_q] <= 1'b0;
					state_q      <= IDLE;
					out_valid_q  <= 1'b1;
					out_status_q <= swqt_pkg::ST_OK;
					out_pvalid_q <= 1'b1;
					out_proc_q   <= done_proc;
				end
				INS_A: begin
					state_q <= INS_B;
				end
				INS_B: begin
					busy_q[hit_idx_q] <= 1'b1;
					waiting_q[pid_q]  <= 1'b1;
					state_q      <= IDLE;
					out_valid_q  <= 1'b1;
					out_status_q <= swqt_pkg::ST_OK;
				end
				RP_SLOT: begin
					hit_idx_q <= pslot_rdata;
					state_q   <= RP_CHK;
				end
				RP_CHK: begin
					hit_key_q  <= slot_rd.key;
					hit_head_q <= slot_rd.head;
					hit_tail_q <= slot_rd.tail;
					cur_q      <= slot_rd.head;
					state_q    <= (slot_rd.head == pid_q) ? POP : RP_WALK;
				end
				RP_WALK: begin
					if (link_rdata == pid_q) begin
						state_q <= RP_FIX;
					end else begin
						cur_q <= link_rdata;
					end
				end
				RP_FIX: begin
					waiting_q[pid_q] <= 1'b0;
					state_q      <= IDLE;
					out_valid_q  <= 1'b1;
					out_status_q <= swqt_pkg::ST_OK;
					out_pvalid_q <= 1'b1;
					out_proc_q   <= pid_q;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/swqt_chk.sv
// port checker for the semaphore wait queue table and its bind
`include "assert_macros.svh"

module swqt_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser
);

	`ASSERT_IMP(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, ##1 m_axis_tvalid, "result dropped while stalled")
	`ASSERT_IMP(a_one_item, clk, arst_n, s_axis_tvalid && s_axis_tready, ##1 !s_axis_tready, "second item taken before result")
	`ASSERT_IMP(a_no_take_pending, clk, arst_n, m_axis_tvalid, !s_axis_tready, "item taken while result pending")
	`ASSERT_IMP(a_proc_ok, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[1:0] == swqt_pkg::ST_OK, "process returned with bad status")
	`ASSERT_IMP(a_proc_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[6:2] == 5'd0, "process field not zero")

endmodule

bind semaphore_wait_queue_table swqt_chk u_swqt_chk (.*);
